// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] item_data;
    logic        [15:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_data;
    logic        [15:0] out_priority;
    logic               head_valid;
    logic signed [31:0] head_data;
    logic        [15:0] head_priority;
    logic        [4:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic        [15:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_DEQ_POP,
    S_DEQ_HEAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    status_t code;
    logic    enq_rd;
    logic    enq_shift;
    logic    enq_put;
    logic    deq_pop;
    logic    deq_head;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_gt1;
    logic rd_ge;
    logic idx_one;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/spq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     ren,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for enqueue insertion scan and dequeue head refill
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     action,
  input  wire dp_stat_t stat,
  output logic          busy,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (action == ACT_ENQ) begin
            if (stat.full) begin
              cmd.code  = ST_FULL;
              state_nxt = S_DONE;
            end else if (stat.empty) begin
              state_nxt = S_ENQ_PUT;
            end else begin
              state_nxt = S_ENQ_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.code  = ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DEQ_POP;
            end
          end
        end
      end
      S_ENQ_RD: begin
        cmd.enq_rd = 1'b1;
        state_nxt  = S_ENQ_CMP;
      end
      S_ENQ_CMP: begin
        if (stat.rd_ge) begin
          state_nxt = S_ENQ_PUT;
        end else begin
          cmd.enq_shift = 1'b1;
          state_nxt     = stat.idx_one ? S_ENQ_PUT : S_ENQ_RD;
        end
      end
      S_ENQ_PUT: begin
        cmd.enq_put = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DEQ_POP: begin
        cmd.deq_pop = 1'b1;
        state_nxt   = stat.cnt_gt1 ? S_DEQ_HEAD : S_DONE;
      end
      S_DEQ_HEAD: begin
        cmd.deq_head = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/spq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp
// circular entry store, head register, occupancy and result register
// ----------------------------------------------------------------------------
module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [AW-1:0] hd_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  entry_t        new_r;
  status_t       st_r;
  entry_t        res_r;
  entry_t        head_r;
  logic          out_valid_r;
  out_item_t     out_r;

  entry_t        rd_entry;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [AW-1:0] addr_next1;
  logic [AW-1:0] addr_idx;
  logic [AW-1:0] addr_idxm1;
  entry_t        wdata;
  logic          we;
  logic          ren;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(k);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign addr_next1 = phys(hd_r, ONE_C);
  assign addr_idx   = phys(hd_r, idx_r);
  assign addr_idxm1 = phys(hd_r, idx_r - ONE_C);

  assign ren   = cmd.enq_rd | cmd.deq_pop;
  assign raddr = cmd.deq_pop ? addr_next1 : addr_idxm1;
  assign we    = cmd.enq_shift | cmd.enq_put;
  assign waddr = addr_idx;
  assign wdata = cmd.enq_put ? new_r : rd_entry;

  spq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .ren  (ren),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  assign stat.full    = (count_r == DEPTH_C);
  assign stat.empty   = (count_r == '0);
  assign stat.cnt_gt1 = (count_r > ONE_C);
  assign stat.rd_ge   = (rd_entry.prio >= new_r.prio);
  assign stat.idx_one = (idx_r == ONE_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.deq_pop) begin
        hd_r    <= addr_next1;
        count_r <= count_r - ONE_C;
      end else if (cmd.enq_put) begin
        count_r <= count_r + ONE_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r      <= count_r;
      new_r.data <= in_item.item_data;
      new_r.prio <= in_item.item_priority;
      st_r       <= cmd.code;
      res_r      <= '0;
    end
    if (cmd.enq_shift) begin
      idx_r <= idx_r - ONE_C;
    end
    if (cmd.enq_put && idx_r == '0) begin
      head_r <= new_r;
    end
    if (cmd.deq_pop) begin
      res_r <= head_r;
    end
    if (cmd.deq_head) begin
      head_r <= rd_entry;
    end
    if (cmd.emit) begin
      out_r.status        <= st_r;
      out_r.out_data      <= res_r.data;
      out_r.out_priority  <= res_r.prio;
      out_r.head_valid    <= (count_r != '0);
      out_r.head_data     <= (count_r != '0) ? head_r.data : '0;
      out_r.head_priority <= (count_r != '0) ? head_r.prio : '0;
      out_r.occupancy     <= 5'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("occupancy exceeds depth");
  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_put |-> !stat.full)
    else $error("insert into full store");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_pop |=> (count_r == $past(count_r) - ONE_C))
    else $error("pop did not decrement occupancy");
`endif

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded priority queue kept in descending priority order, fifo among equals
// ----------------------------------------------------------------------------
// latency from accept to result strobe follows the path: a full or empty reject
// goes to done, a dequeue pops and refills the head when an entry remains, an
// enqueue scans stored entries (one ram read and one compare per entry), then
// writes the new entry; a new item is taken once busy drops, one item at a time
// results cannot be stalled; sync reset empties the queue, entries not cleared
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .action(in_item.action),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |-> (out_item.occupancy == 5'(QUEUE_DEPTH)))
    else $error("full reject with queue not full");
`endif

endmodule

`default_nettype wire
